// ===== rtl/core/lpt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types, codes and helpers of the IPv4 longest prefix table.
// ----------------------------------------------------------------------------
package lpt_pkg;

    localparam int AddrW               = 32;
    localparam int PrefixW             = 6;
    localparam int TableEntriesDefault = 32;
    localparam int QueueDepth          = 2;

    localparam logic [PrefixW-1:0] MaxPrefix = 6'd32;

    // request opcodes, one code for each operation
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // result status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StMiss = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [AddrW-1:0]   address;
        logic [PrefixW-1:0] prefix_length;
        logic [AddrW-1:0]   gateway;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [AddrW-1:0]   matched_address;
        logic [PrefixW-1:0] matched_prefix;
        logic [AddrW-1:0]   matched_gateway;
        logic               inserted;
    } t_rsp;

    // decoded command between front and back
    typedef struct packed {
        t_op                op;
        logic [AddrW-1:0]   address;
        logic [PrefixW-1:0] prefix;
        logic [AddrW-1:0]   gateway;
    } t_cmd;

    // network mask for a prefix length of 0 to 32
    function automatic logic [AddrW-1:0] prefix_mask(input logic [PrefixW-1:0] plen);
        logic [AddrW-1:0] mask;
        if (plen >= MaxPrefix) begin
            mask = '1;
        end else begin
            mask = ~({AddrW{1'b1}} >> plen);
        end
        return mask;
    endfunction

endpackage

// ===== rtl/core/lpt_channels.sv =====
// ----------------------------------------------------------------------------
// lpt channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface lpt_req_if;
    logic          valid;
    logic          ready;
    lpt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpt_rsp_if;
    logic          valid;
    logic          ready;
    lpt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lpt_front.sv =====
// ----------------------------------------------------------------------------
// lpt_front
// Accept request transactions, decode the opcode and clamp the prefix length.
// ----------------------------------------------------------------------------
module lpt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpt_req_if.sink       i_req,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output lpt_pkg::t_cmd o_cmd
);
    import lpt_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd w_dec;

    // take a new transaction when the stage is empty or draining
    assign i_req.ready = !r_valid || i_cmd_ready;

    // decode opcode and saturate prefix length; code 3 (OP_UNUSED) is no operation
    always_comb begin
        w_dec.address = i_req.data.address;
        w_dec.gateway = i_req.data.gateway;
        w_dec.prefix  = (i_req.data.prefix_length > MaxPrefix) ? MaxPrefix
                                                               : i_req.data.prefix_length;
        w_dec.op      = t_op'(i_req.data.opcode);
    end

    // hold the decoded command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= w_dec;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== rtl/core/lpt_queue.sv =====
// ----------------------------------------------------------------------------
// lpt_queue
// Short command queue that decouples the front from the table back end.
// ----------------------------------------------------------------------------
module lpt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  lpt_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output lpt_pkg::t_cmd o_pop_cmd
);
    import lpt_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_cmd            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CntW'(QueueDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // write storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lpt_back.sv =====
// ----------------------------------------------------------------------------
// lpt_back
// Sorted table of subnet cells: parallel compare, first-match selection,
// shift insert, shift delete and gateway update, and the result register.
// ----------------------------------------------------------------------------
module lpt_back #(
    parameter int TABLE_ENTRIES = lpt_pkg::TableEntriesDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  lpt_pkg::t_cmd i_cmd,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output lpt_pkg::t_rsp o_rsp
);
    import lpt_pkg::*;

    localparam int N = TABLE_ENTRIES;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // table cells
    logic               r_cell_valid [N];
    logic [AddrW-1:0]   r_addr [N];
    logic [PrefixW-1:0] r_pfx [N];
    logic [AddrW-1:0]   r_gw [N];

    logic [N-1:0] w_valid;
    logic [N-1:0] w_match_nx;
    logic [N-1:0] w_before_nx;

    // compare results of the command at work
    t_cmd         r_cmd;
    logic [N-1:0] r_match;
    logic [N-1:0] r_before;

    logic               r_out_valid;
    t_rsp               r_out;

    logic               w_pop;
    logic               w_go;
    logic [N-1:0]       w_hit_oh;
    logic               w_hit_any;
    logic [N-1:0]       w_ge;
    logic [N-1:0]       w_g;
    logic               w_full;
    logic               w_do_delete;
    logic               w_do_insert;
    logic               w_do_update;
    logic [AddrW-1:0]   w_sel_addr;
    logic [PrefixW-1:0] w_sel_pfx;
    logic [AddrW-1:0]   w_sel_gw;
    t_rsp               w_rsp;

    assign w_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_go        = (r_state == S_EXEC) && (!r_out_valid || i_rsp_ready);

    // first match, shift regions and table full
    assign w_hit_oh  = r_match & (~r_match + 1'b1);
    assign w_hit_any = |r_match;
    assign w_ge      = ~(w_hit_oh - 1'b1);
    assign w_g       = r_before | ~w_valid;
    assign w_full    = w_valid[N-1];

    assign w_do_delete = (r_cmd.op == OP_DELETE) && w_hit_any;
    assign w_do_update = (r_cmd.op == OP_ADD) && w_hit_any;
    assign w_do_insert = (r_cmd.op == OP_ADD) && !w_hit_any && !w_full;

    // select the matching cell
    always_comb begin
        w_sel_addr = '0;
        w_sel_pfx  = '0;
        w_sel_gw   = '0;
        for (int i = 0; i < N; i++) begin
            w_sel_addr = w_sel_addr | (r_addr[i] & {AddrW{w_hit_oh[i]}});
            w_sel_pfx  = w_sel_pfx | (r_pfx[i] & {PrefixW{w_hit_oh[i]}});
            w_sel_gw   = w_sel_gw | (r_gw[i] & {AddrW{w_hit_oh[i]}});
        end
    end

    // build the result
    always_comb begin
        w_rsp = '0;
        w_rsp.status = StMiss;
        unique case (r_cmd.op)
            OP_LOOKUP, OP_DELETE: begin
                if (w_hit_any) begin
                    w_rsp.status          = StOk;
                    w_rsp.matched_address = w_sel_addr;
                    w_rsp.matched_prefix  = w_sel_pfx;
                    w_rsp.matched_gateway = w_sel_gw;
                end
            end
            OP_ADD: begin
                if (w_hit_any) begin
                    w_rsp.status          = StOk;
                    w_rsp.matched_address = w_sel_addr;
                    w_rsp.matched_prefix  = w_sel_pfx;
                    w_rsp.matched_gateway = r_cmd.gateway;
                end else if (w_full) begin
                    w_rsp.status = StFull;
                end else begin
                    w_rsp.status          = StOk;
                    w_rsp.matched_address = r_cmd.address;
                    w_rsp.matched_prefix  = r_cmd.prefix;
                    w_rsp.matched_gateway = r_cmd.gateway;
                    w_rsp.inserted        = 1'b1;
                end
            end
            OP_UNUSED: begin
                w_rsp.status = StMiss;
            end
        endcase
    end

    // per-cell compare and update
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        logic [AddrW-1:0]   dn_addr;
        logic [PrefixW-1:0] dn_pfx;
        logic [AddrW-1:0]   dn_gw;
        logic               dn_valid;
        logic [AddrW-1:0]   up_addr;
        logic [PrefixW-1:0] up_pfx;
        logic [AddrW-1:0]   up_gw;
        logic               up_valid;
        logic               prev_g;

        assign w_valid[gi] = r_cell_valid[gi];

        // match under the stored mask; sorted place of a new entry
        assign w_match_nx[gi] = r_cell_valid[gi] &&
            (((i_cmd.address ^ r_addr[gi]) & prefix_mask(r_pfx[gi])) == '0);
        assign w_before_nx[gi] = r_cell_valid[gi] &&
            ((i_cmd.prefix > r_pfx[gi]) ||
             ((i_cmd.prefix == r_pfx[gi]) && (i_cmd.address < r_addr[gi])));

        if (gi == N - 1) begin : g_top
            assign dn_addr  = r_addr[gi];
            assign dn_pfx   = r_pfx[gi];
            assign dn_gw    = r_gw[gi];
            assign dn_valid = 1'b0;
        end else begin : g_mid
            assign dn_addr  = r_addr[gi+1];
            assign dn_pfx   = r_pfx[gi+1];
            assign dn_gw    = r_gw[gi+1];
            assign dn_valid = r_cell_valid[gi+1];
        end

        if (gi == 0) begin : g_bottom
            assign up_addr  = r_addr[gi];
            assign up_pfx   = r_pfx[gi];
            assign up_gw    = r_gw[gi];
            assign up_valid = r_cell_valid[gi];
            assign prev_g   = 1'b0;
        end else begin : g_upper
            assign up_addr  = r_addr[gi-1];
            assign up_pfx   = r_pfx[gi-1];
            assign up_gw    = r_gw[gi-1];
            assign up_valid = r_cell_valid[gi-1];
            assign prev_g   = w_g[gi-1];
        end

        // valid mark: shift down on delete, shift up or fill on insert
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cell_valid[gi] <= 1'b0;
            end else if (w_go) begin
                if (w_do_delete && w_ge[gi]) begin
                    r_cell_valid[gi] <= dn_valid;
                end else if (w_do_insert && w_g[gi]) begin
                    r_cell_valid[gi] <= prev_g ? up_valid : 1'b1;
                end
            end
        end

        // cell payload
        always_ff @(posedge i_clk) begin
            if (w_go) begin
                if (w_do_delete && w_ge[gi]) begin
                    r_addr[gi] <= dn_addr;
                    r_pfx[gi]  <= dn_pfx;
                    r_gw[gi]   <= dn_gw;
                end else if (w_do_insert && w_g[gi]) begin
                    if (prev_g) begin
                        r_addr[gi] <= up_addr;
                        r_pfx[gi]  <= up_pfx;
                        r_gw[gi]   <= up_gw;
                    end else begin
                        r_addr[gi] <= r_cmd.address;
                        r_pfx[gi]  <= r_cmd.prefix;
                        r_gw[gi]   <= r_cmd.gateway;
                    end
                end else if (w_do_update && w_hit_oh[gi]) begin
                    r_gw[gi] <= r_cmd.gateway;
                end
            end
        end
    end

    // sequencer: compare on pop, execute when the result register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture command, compare vectors and result payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd    <= i_cmd;
            r_match  <= w_match_nx;
            r_before <= w_before_nx;
        end
        if (w_go) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // valid cells stay packed from the bottom
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid cells not contiguous");

    // an insert adds exactly one valid cell
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_do_insert) |=> ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add one entry");

    // a delete removes exactly one valid cell
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_do_delete) |=> ($countones(w_valid) + 1 == $past($countones(w_valid))))
        else $error("delete did not remove one entry");

    // a match only ever comes from a valid cell
    a_match_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ((w_hit_oh & ~w_valid) == '0))
        else $error("match on an empty cell");

endmodule

// ===== rtl/core/ipv4_longest_prefix_table_core.sv =====
// Path: a request passes the front register, the command queue, the back-end compare registers and the result register.
// The back end takes a new command only after the compare and execute steps
//   of the previous one; the front register and the queue hold requests meanwhile.
// Reset: synchronous, active low; clears the valid marks of all cells in the
//   reset cycle, so the table is empty right after reset without a clearing pass.
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_table_core
// IPv4 subnet table kept sorted for longest prefix match: lookup, add or
// update gateway, and delete, with a decoupled front end and table back end.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_table_core #(
    parameter int TABLE_ENTRIES = lpt_pkg::TableEntriesDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lpt_req_if.sink   i_req,
    lpt_rsp_if.source o_rsp
);
    import lpt_pkg::*;

    logic w_front_valid;
    logic w_front_ready;
    t_cmd w_front_cmd;
    logic w_head_valid;
    logic w_head_ready;
    t_cmd w_head_cmd;
    logic w_rsp_valid;
    t_rsp w_rsp;

    // accept and decode
    lpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    // decouple front and back
    lpt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_cmd   (w_front_cmd),
        .o_pop_valid  (w_head_valid),
        .i_pop_ready  (w_head_ready),
        .o_pop_cmd    (w_head_cmd)
    );

    // table and result register
    lpt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .o_cmd_ready (w_head_ready),
        .i_cmd       (w_head_cmd),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.valid = w_rsp_valid;
    assign o_rsp.data  = w_rsp;

endmodule

// ===== test/ipv4_longest_prefix_table_core_test.sv =====
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_table_core_test
// Self-checking bench for the subnet table: drives lookup, add and delete
// requests with random gaps and a long result stall, keeps its own sorted copy
// of the table to predict each reply, and compares replies field by field.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_table_core_test;
    import lpt_pkg::*;

    localparam int Entries       = TableEntriesDefault;
    localparam int IdlePercent   = 8;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 12;

    logic i_clk;
    logic i_rst_n;

    lpt_req_if req_if ();
    lpt_rsp_if rsp_if ();

    ipv4_longest_prefix_table_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the route table, slots 0..route_count-1 in use
    logic [AddrW-1:0]   route_addr [Entries];
    logic [PrefixW-1:0] route_plen [Entries];
    logic [AddrW-1:0]   route_gw   [Entries];
    int                 route_count = 0;

    t_rsp route_replies_q [$];
    int   fail_count    = 0;
    bit   steady_flow   = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    logic [AddrW-1:0] subnet_pool [16];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [AddrW-1:0] net_mask(input logic [PrefixW-1:0] plen);
        return (plen == 0) ? '0 : ({AddrW{1'b1}} << (AddrW - plen));
    endfunction

    // apply one request to the shadow table and return the reply it gives
    function automatic t_rsp apply_route_op(input t_req req);
        t_rsp             rsp;
        logic [PrefixW-1:0] plen;
        int               hit;
        int               pos;
        rsp        = '0;
        rsp.status = StMiss;
        plen       = (req.prefix_length > MaxPrefix) ? MaxPrefix : req.prefix_length;
        hit        = -1;
        for (int i = 0; i < route_count; i++) begin
            if (hit < 0 && ((req.address ^ route_addr[i]) & net_mask(route_plen[i])) == 0)
                hit = i;
        end
        case (req.opcode)
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    rsp = {StOk, route_addr[hit], route_plen[hit], route_gw[hit], 1'b0};
                end
            end
            OP_DELETE: begin
                if (hit >= 0) begin
                    rsp = {StOk, route_addr[hit], route_plen[hit], route_gw[hit], 1'b0};
                    for (int i = hit; i + 1 < route_count; i++) begin
                        route_addr[i] = route_addr[i+1];
                        route_plen[i] = route_plen[i+1];
                        route_gw[i]   = route_gw[i+1];
                    end
                    route_count--;
                end
            end
            OP_ADD: begin
                if (hit >= 0) begin
                    // covered subnet: overwrite gateway, keep stored prefix
                    route_gw[hit] = req.gateway;
                    rsp = {StOk, route_addr[hit], route_plen[hit], req.gateway, 1'b0};
                end else if (route_count >= Entries) begin
                    rsp.status = StFull;
                end else begin
                    pos = route_count;
                    for (int i = route_count - 1; i >= 0; i--) begin
                        if (plen > route_plen[i] ||
                            (plen == route_plen[i] && req.address < route_addr[i]))
                            pos = i;
                    end
                    for (int i = route_count; i > pos; i--) begin
                        route_addr[i] = route_addr[i-1];
                        route_plen[i] = route_plen[i-1];
                        route_gw[i]   = route_gw[i-1];
                    end
                    route_addr[pos] = req.address;
                    route_plen[pos] = plen;
                    route_gw[pos]   = req.gateway;
                    route_count++;
                    rsp = {StOk, req.address, plen, req.gateway, 1'b1};
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [AddrW-1:0] want,
                               input logic [AddrW-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // predict on each accepted request, check each accepted reply
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
                route_replies_q.push_back(apply_route_op(req_if.data));
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got = rsp_if.data;
                if (route_replies_q.size() == 0) begin
                    $error("reply arrived with no request pending");
                    fail_count++;
                end else begin
                    want = route_replies_q.pop_front();
                    check_field("status", AddrW'(want.status), AddrW'(got.status));
                    check_field("matched_address", want.matched_address,
                                got.matched_address);
                    check_field("matched_prefix", AddrW'(want.matched_prefix),
                                AddrW'(got.matched_prefix));
                    check_field("matched_gateway", want.matched_gateway,
                                got.matched_gateway);
                    check_field("inserted", AddrW'(want.inserted), AddrW'(got.inserted));
                end
            end
        end
    end

    // reply side: hold off on request, otherwise stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            rsp_if.ready <= steady_flow || ($urandom_range(99) >= IdlePercent);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request and wait until the block takes it
    task automatic send_request(input t_op op, input logic [AddrW-1:0] addr,
                                input logic [PrefixW-1:0] plen,
                                input logic [AddrW-1:0] gw);
        t_req req;
        req.opcode        = op;
        req.address       = addr;
        req.prefix_length = plen;
        req.gateway       = gw;
        if (!steady_flow) begin
            while ($urandom_range(99) < IdlePercent) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    // nested subnets come from a small pool of bases with random host bits
    function automatic logic [AddrW-1:0] pick_address();
        logic [AddrW-1:0] base;
        if ($urandom_range(4) == 0) return $urandom;
        base = subnet_pool[4'($urandom_range(15))];
        return base ^ ($urandom & ~net_mask(PrefixW'($urandom_range(32))));
    endfunction

    function automatic logic [PrefixW-1:0] pick_prefix();
        int r;
        r = $urandom_range(99);
        if (r < 2) return '0;
        if (r < 5) return PrefixW'($urandom_range(63, 33));
        return PrefixW'($urandom_range(32, 1));
    endfunction

    function automatic t_op pick_op(input int add_w, input int del_w);
        int r;
        r = $urandom_range(99);
        if (r < 3) return OP_UNUSED;
        if (r < 3 + add_w) return OP_ADD;
        if (r < 3 + add_w + del_w) return OP_DELETE;
        return OP_LOOKUP;
    endfunction

    // empty table, extremes, covering adds, saturation, default route
    task automatic test_directed();
        send_request(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'h0A01_024D, 6'd24, 32'h0000_0001);
        send_request(OP_ADD, 32'h0A01_0000, 6'd16, 32'h0000_0002);
        send_request(OP_ADD, 32'h0A01_0205, 6'd63, 32'h0000_0003);
        send_request(OP_ADD, 32'hC0A8_0001, 6'd40, 32'h0000_0004);
        send_request(OP_LOOKUP, 32'h0A01_02C8, 6'd63, 32'h0);
        send_request(OP_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0);
        send_request(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
        send_request(OP_ADD, 32'h0000_0000, 6'd0, 32'h0000_DEAD);
        send_request(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
        send_request(OP_ADD, 32'h7F00_0001, 6'd8, 32'h0000_0005);
        send_request(OP_DELETE, 32'h0A01_0201, 6'd0, 32'h0);
        send_request(OP_LOOKUP, 32'h0A01_0201, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'h5555_5555, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'h0A01_0000, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'hC0A8_0001, 6'd0, 32'h0);
        send_request(OP_LOOKUP, 32'hC0A8_0001, 6'd0, 32'h0);
        send_request(OP_ADD, 32'h0000_0001, 6'd32, 32'h0000_0000);
        send_request(OP_ADD, 32'h0000_0000, 6'd32, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0000_0000, 6'd0, 32'h0);
        send_request(OP_DELETE, 32'h0000_0001, 6'd0, 32'h0);
    endtask

    // fill past capacity, update while full, then drain by delete
    task automatic test_table_full();
        logic [AddrW-1:0] fill_addr [Entries + 4];
        foreach (fill_addr[i]) begin
            fill_addr[i] = $urandom;
            send_request(OP_ADD, fill_addr[i], 6'd28, $urandom);
        end
        send_request(OP_ADD, fill_addr[0] ^ 32'h0000_0007, 6'd32, $urandom);
        send_request(OP_LOOKUP, fill_addr[3], 6'd0, 32'h0);
        foreach (fill_addr[i])
            send_request(OP_DELETE, fill_addr[i], PrefixW'($urandom_range(63)), 32'h0);
    endtask

    // stall replies for a long stretch while requests keep coming
    task automatic test_reply_backpressure();
        steady_flow = 1'b1;
        hold_left   = 400;
        repeat (40) send_request(pick_op(45, 20), pick_address(), pick_prefix(), $urandom);
        steady_flow = 1'b0;
    endtask

    // rounds that lean toward adds, then toward deletes, one without idling
    task automatic test_random_mix();
        foreach (subnet_pool[i]) subnet_pool[i] = $urandom;
        subnet_pool[0] = 32'h0000_0000;
        subnet_pool[1] = 32'hFFFF_FFFF;
        for (int round = 0; round < 4; round++) begin
            steady_flow = (round == 2);
            repeat (270) begin
                t_op op;
                op = (round % 2 == 0) ? pick_op(55, 20) : pick_op(20, 50);
                send_request(op, pick_address(),
                             (op == OP_ADD) ? pick_prefix() : PrefixW'($urandom_range(63)),
                             $urandom);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_reply_backpressure();
        test_random_mix();

        // release the request line, drain replies, then allow stragglers
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (route_replies_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lpt_pkg.sv
rtl/core/lpt_channels.sv
rtl/core/lpt_front.sv
rtl/core/lpt_queue.sv
rtl/core/lpt_back.sv
rtl/core/ipv4_longest_prefix_table_core.sv
test/ipv4_longest_prefix_table_core_test.sv
